FILE: hdl/cbs_pkg.sv
// Shared types, command and status structs, and constant tables for the curve smoother.
`default_nettype none
package cbs_pkg;

   // Unsigned fraction 1.0 with 16 fraction bits.
   localparam logic [16:0] ONE_FRAC = 17'h10000;

   // Width of the segment count register.
   localparam int SEG_WIDTH = 5;

   // Reset value of the segment count register.
   localparam logic [SEG_WIDTH-1:0] SEG_RESET = 5'd16;

   // Quotient of 65536 by the segment count (entry 0 stands in for 1).
   localparam logic [16:0] STEP_Q [32] = '{
      17'd65536, 17'd65536, 17'd32768, 17'd21845, 17'd16384, 17'd13107, 17'd10922, 17'd9362,
      17'd8192,  17'd7281,  17'd6553,  17'd5957,  17'd5461,  17'd5041,  17'd4681,  17'd4369,
      17'd4096,  17'd3855,  17'd3640,  17'd3449,  17'd3276,  17'd3120,  17'd2978,  17'd2849,
      17'd2730,  17'd2621,  17'd2520,  17'd2427,  17'd2340,  17'd2259,  17'd2184,  17'd2114
   };

   // Remainder of 65536 by the segment count.
   localparam logic [4:0] STEP_R [32] = '{
      5'd0, 5'd0, 5'd0,  5'd1,  5'd0,  5'd1,  5'd4,  5'd2,
      5'd0, 5'd7, 5'd6,  5'd9,  5'd4,  5'd3,  5'd2,  5'd1,
      5'd0, 5'd1, 5'd16, 5'd5,  5'd16, 5'd16, 5'd20, 5'd9,
      5'd16, 5'd11, 5'd16, 5'd7, 5'd16, 5'd25, 5'd16, 5'd2
   };

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic                 load;        // capture geometry for a new point
      logic                 load_line;   // span 0 is a straight line
      logic                 load_pass;   // span 0 is the single point itself
      logic                 first_span;  // start of polyline: end offset from the span itself
      logic                 shift_window;
      logic                 issue;       // start one sample down the pipeline
      logic                 restart;     // next sample starts a new span at t = 0
      logic                 line_mode;
      logic                 span_sel;
      logic                 run_last;
      logic                 curve_end;
      logic [SEG_WIDTH-1:0] seg;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic busy;     // samples still need the span registers
      logic advance;  // pipeline moves this cycle
   } status_type;

endpackage
`default_nettype wire

FILE: hdl/cubic_bezier_curve_smoother.sv
// Top level of the cubic Bezier curve smoother: controller plus datapath.
//
//  channel | direction | handshake           | payload
//  req     | in        | req_valid/req_stall | req_point_x, req_point_y, req_last_point
//  rsp     | out       | rsp_valid/rsp_stall | rsp_curve_x, rsp_curve_y, rsp_run_last,
//          |           |                     | rsp_curve_end
//  csr     | in        | csr_wr_en           | csr_wr_data (segment count)
//
// Samples leave at one per cycle while the output is not stalled: a span gives
// segment_count+1 samples, and a final point of three or more takes two spans. After its
// last sample issues, a point waits for the pipeline to release the span registers
// before the next transfer. A sample passes through stages 1 to 4 into the output register.
// Reset is synchronous and clears control state; the segment count returns to 16.
// An output stall freezes the whole sample pipeline.
`default_nettype none
module cubic_bezier_curve_smoother #(
   parameter int COORD_WIDTH  = 24,
   parameter int MAX_SEGMENTS = 31
) (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           req_valid,
   output logic                          req_stall,
   input  wire signed [COORD_WIDTH-1:0]  req_point_x,
   input  wire signed [COORD_WIDTH-1:0]  req_point_y,
   input  wire                           req_last_point,
   output logic                          rsp_valid,
   input  wire                           rsp_stall,
   output logic signed [COORD_WIDTH-1:0] rsp_curve_x,
   output logic signed [COORD_WIDTH-1:0] rsp_curve_y,
   output logic                          rsp_run_last,
   output logic                          rsp_curve_end,
   input  wire                           csr_wr_en,
   input  wire  [cbs_pkg::SEG_WIDTH-1:0] csr_wr_data
);

   cbs_pkg::cmd_type    cmd;
   cbs_pkg::status_type status;

   cbs_ctrl #(
      .MAX_SEGMENTS (MAX_SEGMENTS)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_last_point (req_last_point),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .status         (status),
      .cmd            (cmd)
   );

   cbs_datapath #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .req_point_x   (req_point_x),
      .req_point_y   (req_point_y),
      .cmd           (cmd),
      .status        (status),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_curve_x   (rsp_curve_x),
      .rsp_curve_y   (rsp_curve_y),
      .rsp_run_last  (rsp_run_last),
      .rsp_curve_end (rsp_curve_end)
   );

endmodule
`default_nettype wire

FILE: hdl/cbs_ctrl.sv
// Controller state machine: point intake, span sequencing and sample issue.
`default_nettype none
module cbs_ctrl #(
   parameter int MAX_SEGMENTS = 31
) (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            req_valid,
   output logic                           req_stall,
   input  wire                            req_last_point,
   input  wire                            csr_wr_en,
   input  wire  [cbs_pkg::SEG_WIDTH-1:0]  csr_wr_data,
   input  cbs_pkg::status_type            status,
   output cbs_pkg::cmd_type               cmd
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_RUN  = 1'b1;

   localparam logic [cbs_pkg::SEG_WIDTH-1:0] SEG_MAX = cbs_pkg::SEG_WIDTH'(MAX_SEGMENTS);

   logic                          state_ff, state_in;
   logic [1:0]                    seen_ff, seen_in;
   logic [cbs_pkg::SEG_WIDTH-1:0] seg_ff, seg_in;
   logic [cbs_pkg::SEG_WIDTH-1:0] j_ff, j_in;
   logic [cbs_pkg::SEG_WIDTH-1:0] end_ff, end_in;
   logic                          more_ff, more_in;
   logic                          last_ff, last_in;
   logic                          sel_ff, sel_in;
   logic                          line_ff, line_in;
   logic [cbs_pkg::SEG_WIDTH-1:0] seg_eff;
   logic                          accept, issue, at_end;

   // Segment count clamped to its legal range.
   always_comb begin
      if (seg_ff == '0) begin
         seg_eff = cbs_pkg::SEG_WIDTH'(1);
      end else if (seg_ff > SEG_MAX) begin
         seg_eff = SEG_MAX;
      end else begin
         seg_eff = seg_ff;
      end
   end

   assign req_stall = !((state_ff == ST_IDLE) && !status.busy);
   assign accept    = req_valid && !req_stall;
   assign issue     = (state_ff == ST_RUN) && status.advance;
   assign at_end    = (j_ff == end_ff);

   // Next-state logic for intake and sequencing.
   always_comb begin
      state_in = state_ff;
      seen_in  = seen_ff;
      seg_in   = seg_ff;
      j_in     = j_ff;
      end_in   = end_ff;
      more_in  = more_ff;
      last_in  = last_ff;
      sel_in   = sel_ff;
      line_in  = line_ff;

      if (csr_wr_en) begin
         seg_in = csr_wr_data;
      end

      if (accept) begin
         j_in    = '0;
         sel_in  = 1'b0;
         last_in = req_last_point;
         more_in = 1'b0;
         case (seen_ff)
            2'd0: begin
               line_in = 1'b1;
               end_in  = '0;
               if (req_last_point) begin
                  state_in = ST_RUN;
               end
            end
            2'd1: begin
               line_in = 1'b1;
               end_in  = seg_eff;
               if (req_last_point) begin
                  state_in = ST_RUN;
               end
            end
            default: begin
               line_in  = 1'b0;
               end_in   = seg_eff;
               more_in  = req_last_point;
               state_in = ST_RUN;
            end
         endcase
         if (req_last_point) begin
            seen_in = '0;
         end else if (seen_ff != 2'd3) begin
            seen_in = seen_ff + 2'd1;
         end
      end else if (issue) begin
         if (at_end) begin
            if (more_ff) begin
               sel_in  = 1'b1;
               more_in = 1'b0;
               j_in    = '0;
            end else begin
               state_in = ST_IDLE;
            end
         end else begin
            j_in = j_ff + cbs_pkg::SEG_WIDTH'(1);
         end
      end
   end

   // Command outputs.
   always_comb begin
      cmd              = '0;
      cmd.load         = accept;
      cmd.load_line    = seen_ff inside {2'd0, 2'd1};
      cmd.load_pass    = (seen_ff == 2'd0);
      cmd.first_span   = (seen_ff == 2'd2);
      cmd.shift_window = accept && !req_last_point;
      cmd.issue        = issue;
      cmd.restart      = accept || (issue && at_end);
      cmd.line_mode    = line_ff;
      cmd.span_sel     = sel_ff;
      cmd.run_last     = issue && at_end && !more_ff;
      cmd.curve_end    = issue && at_end && !more_ff && last_ff;
      cmd.seg          = seg_eff;
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         seen_ff  <= '0;
         seg_ff   <= cbs_pkg::SEG_RESET;
         j_ff     <= '0;
         end_ff   <= '0;
         more_ff  <= 1'b0;
         last_ff  <= 1'b0;
         sel_ff   <= 1'b0;
         line_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         seen_ff  <= seen_in;
         seg_ff   <= seg_in;
         j_ff     <= j_in;
         end_ff   <= end_in;
         more_ff  <= more_in;
         last_ff  <= last_in;
         sel_ff   <= sel_in;
         line_ff  <= line_in;
      end
   end

endmodule
`default_nettype wire

FILE: hdl/cbs_datapath.sv
// Datapath: point window, control points, t stepper and the sample pipeline.
`default_nettype none
module cbs_datapath #(
   parameter int COORD_WIDTH = 24
) (
   input  wire                           clock,
   input  wire                           reset,
   input  wire signed [COORD_WIDTH-1:0]  req_point_x,
   input  wire signed [COORD_WIDTH-1:0]  req_point_y,
   input  cbs_pkg::cmd_type              cmd,
   output cbs_pkg::status_type           status,
   output logic                          rsp_valid,
   input  wire                           rsp_stall,
   output logic signed [COORD_WIDTH-1:0] rsp_curve_x,
   output logic signed [COORD_WIDTH-1:0] rsp_curve_y,
   output logic                          rsp_run_last,
   output logic                          rsp_curve_end
);

   localparam int XW = COORD_WIDTH + 1;   // control points
   localparam int PW = XW + 19;           // one weighted term
   localparam int SW = XW + 21;           // sum of four terms
   localparam longint HI_L = (longint'(1) <<< (COORD_WIDTH - 1)) - 1;
   localparam longint LO_L = -HI_L - 1;
   localparam logic signed [SW-1:0] SAT_HI = SW'(HI_L);
   localparam logic signed [SW-1:0] SAT_LO = SW'(LO_L);

   logic advance;

   // Window of the last three points and the geometry of two spans per axis.
   logic signed [COORD_WIDTH-1:0] win_ff [2][3];
   logic signed [XW-1:0]          sp_ff  [2][2][4];
   logic signed [COORD_WIDTH-1:0] pt     [2];

   assign pt[0] = req_point_x;
   assign pt[1] = req_point_y;

   for (genvar a = 0; a < 2; a++) begin : g_geom
      logic signed [XW-1:0] cur, prev, prev2, prev3;
      logic signed [XW-1:0] q_pp, q_p2, q_cp, d_cp;

      assign cur   = XW'(pt[a]);
      assign prev  = XW'(win_ff[a][2]);
      assign prev2 = XW'(win_ff[a][1]);
      assign prev3 = XW'(win_ff[a][0]);
      assign d_cp  = cur - prev;
      assign q_pp  = (prev - prev2) >>> 2;
      assign q_p2  = (prev2 - prev3) >>> 2;
      assign q_cp  = d_cp >>> 2;

      // Capture control points when a point is taken.
      always_ff @(posedge clock) begin
         if (cmd.load) begin
            if (cmd.load_line) begin
               sp_ff[a][0][0] <= cmd.load_pass ? cur : prev;
               sp_ff[a][0][1] <= cmd.load_pass ? '0 : d_cp;
               sp_ff[a][0][2] <= '0;
               sp_ff[a][0][3] <= '0;
            end else begin
               sp_ff[a][0][0] <= prev2;
               sp_ff[a][0][1] <= prev2 + (cmd.first_span ? q_pp : q_p2);
               sp_ff[a][0][2] <= prev - q_cp;
               sp_ff[a][0][3] <= prev;
            end
            sp_ff[a][1][0] <= prev;
            sp_ff[a][1][1] <= prev + q_pp;
            sp_ff[a][1][2] <= cur - q_cp;
            sp_ff[a][1][3] <= cur;
         end
         if (cmd.shift_window) begin
            win_ff[a][0] <= win_ff[a][1];
            win_ff[a][1] <= win_ff[a][2];
            win_ff[a][2] <= pt[a];
         end
      end
   end

   // Pipeline moves whenever the output register is free or being taken.
   assign advance        = !rsp_valid || !rsp_stall;
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   assign status.advance = advance;
   assign status.busy    = v1_ff || v2_ff;

   // The t stepper: t = floor(j * 65536 / seg), kept with its remainder.
   logic [16:0] t_ff;
   logic [4:0]  rem_ff;
   logic [5:0]  rsum;
   logic        carry;

   assign rsum  = {1'b0, rem_ff} + {1'b0, cbs_pkg::STEP_R[cmd.seg]};
   assign carry = (rsum >= {1'b0, cmd.seg});

   always_ff @(posedge clock) begin
      if (cmd.restart) begin
         t_ff   <= '0;
         rem_ff <= '0;
      end else if (cmd.issue) begin
         t_ff   <= t_ff + cbs_pkg::STEP_Q[cmd.seg] + 17'(carry);
         rem_ff <= carry ? 5'(rsum - {1'b0, cmd.seg}) : rsum[4:0];
      end
   end

   // Stage 1: squares of u and t.
   logic [16:0] t1_ff, u1_ff, uu1_ff, tt1_ff;
   logic        line1_ff, sel1_ff, rl1_ff, ce1_ff;
   logic [16:0] u0;
   logic [33:0] uu_raw, tt_raw;

   assign u0     = cbs_pkg::ONE_FRAC - t_ff;
   assign uu_raw = 34'(u0) * 34'(u0);
   assign tt_raw = 34'(t_ff) * 34'(t_ff);

   always_ff @(posedge clock) begin
      if (advance) begin
         t1_ff    <= t_ff;
         u1_ff    <= u0;
         uu1_ff   <= uu_raw[32:16];
         tt1_ff   <= tt_raw[32:16];
         line1_ff <= cmd.line_mode;
         sel1_ff  <= cmd.span_sel;
         rl1_ff   <= cmd.run_last;
         ce1_ff   <= cmd.curve_end;
      end
   end

   // Stage 2: the four Bernstein weights, or the line weights.
   logic [17:0] w2_ff [4];
   logic        sel2_ff, rl2_ff, ce2_ff;
   logic [33:0] p_uuu, p_uut, p_utt, p_ttt;
   logic [18:0] w1x3, w2x3;

   assign p_uuu = 34'(uu1_ff) * 34'(u1_ff);
   assign p_uut = 34'(uu1_ff) * 34'(t1_ff);
   assign p_utt = 34'(u1_ff) * 34'(tt1_ff);
   assign p_ttt = 34'(tt1_ff) * 34'(t1_ff);
   assign w1x3  = 19'(p_uut[32:16]) * 19'd3;
   assign w2x3  = 19'(p_utt[32:16]) * 19'd3;

   always_ff @(posedge clock) begin
      if (advance) begin
         if (line1_ff) begin
            w2_ff[0] <= 18'(cbs_pkg::ONE_FRAC);
            w2_ff[1] <= 18'(t1_ff);
            w2_ff[2] <= '0;
            w2_ff[3] <= '0;
         end else begin
            w2_ff[0] <= 18'(p_uuu[32:16]);
            w2_ff[1] <= w1x3[17:0];
            w2_ff[2] <= w2x3[17:0];
            w2_ff[3] <= 18'(p_ttt[32:16]);
         end
         sel2_ff <= sel1_ff;
         rl2_ff  <= rl1_ff;
         ce2_ff  <= ce1_ff;
      end
   end

   // Stage 3: weighted terms; stage 4: their sum.
   logic signed [PW-1:0] m3_ff [2][4];
   logic signed [SW-1:0] s4_ff [2];
   logic                 rl3_ff, ce3_ff, rl4_ff, ce4_ff;

   for (genvar a = 0; a < 2; a++) begin : g_axis
      always_ff @(posedge clock) begin
         if (advance) begin
            for (int k = 0; k < 4; k++) begin
               m3_ff[a][k] <= PW'(sp_ff[a][sel2_ff][k]) * PW'($signed({1'b0, w2_ff[k]}));
            end
            s4_ff[a] <= SW'(m3_ff[a][0]) + SW'(m3_ff[a][1])
                      + SW'(m3_ff[a][2]) + SW'(m3_ff[a][3]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rl3_ff <= rl2_ff;
         ce3_ff <= ce2_ff;
         rl4_ff <= rl3_ff;
         ce4_ff <= ce3_ff;
      end
   end

   // Floor shift and saturation into the output register.
   logic signed [SW-1:0]          sh [2];
   logic signed [COORD_WIDTH-1:0] sat [2];

   for (genvar a = 0; a < 2; a++) begin : g_sat
      assign sh[a] = s4_ff[a] >>> 16;
      always_comb begin
         if (sh[a] > SAT_HI) begin
            sat[a] = SAT_HI[COORD_WIDTH-1:0];
         end else if (sh[a] < SAT_LO) begin
            sat[a] = SAT_LO[COORD_WIDTH-1:0];
         end else begin
            sat[a] = sh[a][COORD_WIDTH-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_curve_x   <= sat[0];
         rsp_curve_y   <= sat[1];
         rsp_run_last  <= rl4_ff;
         rsp_curve_end <= ce4_ff;
      end
   end

   // Stage valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff     <= 1'b0;
         v2_ff     <= 1'b0;
         v3_ff     <= 1'b0;
         v4_ff     <= 1'b0;
         rsp_valid <= 1'b0;
      end else if (advance) begin
         v1_ff     <= cmd.issue;
         v2_ff     <= v1_ff;
         v3_ff     <= v2_ff;
         v4_ff     <= v3_ff;
         rsp_valid <= v4_ff;
      end
   end

endmodule
`default_nettype wire

FILE: tb/sv/tb_cubic_bezier_curve_smoother.sv
// Testbench for the cubic Bezier curve smoother: directed and random point streams.
`timescale 1ns / 1ps
module tb_cubic_bezier_curve_smoother;

   localparam int CW = 24;
   localparam int CYCLE_LIMIT = 2000000;

   typedef struct {
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic                 run_last;
      logic                 curve_end;
   } sample_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [CW-1:0] req_point_x = '0;
   logic signed [CW-1:0] req_point_y = '0;
   logic req_last_point = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [CW-1:0] rsp_curve_x;
   logic signed [CW-1:0] rsp_curve_y;
   logic rsp_run_last;
   logic rsp_curve_end;
   logic csr_wr_en = 1'b0;
   logic [cbs_pkg::SEG_WIDTH-1:0] csr_wr_data = '0;

   cubic_bezier_curve_smoother uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_point_x(req_point_x), .req_point_y(req_point_y),
      .req_last_point(req_last_point),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_curve_x(rsp_curve_x), .rsp_curve_y(rsp_curve_y),
      .rsp_run_last(rsp_run_last), .rsp_curve_end(rsp_curve_end),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Predictor state.
   longint win_x [3];
   longint win_y [3];
   int     pts_in_curve;
   int     seg_reg;
   sample_type pending_samples [$];
   int     error_count;
   int     sample_count;
   int     point_count;
   int     cycle_count;
   bit     idle_enable;

   function automatic longint floor_div(longint v, int s);
      return v >>> s;
   endfunction

   function automatic logic [CW-1:0] clamp(longint v);
      if (v > 64'sd8388607) return 24'h7fffff;
      if (v < -64'sd8388608) return 24'h800000;
      return v[CW-1:0];
   endfunction

   function automatic void push_sample(longint x, longint y);
      sample_type s;
      s.x = clamp(x);
      s.y = clamp(y);
      s.run_last = 1'b0;
      s.curve_end = 1'b0;
      pending_samples = {pending_samples, s};
   endfunction

   function automatic void sample_line(longint ax, longint ay, longint bx, longint by,
                                       int seg);
      longint t;
      for (int j = 0; j <= seg; j++) begin
         t = (longint'(j) << 16) / seg;
         push_sample(ax + floor_div((bx - ax) * t, 16), ay + floor_div((by - ay) * t, 16));
      end
   endfunction

   function automatic void sample_span(longint p0x, longint p0y, longint c1x, longint c1y,
                                       longint c2x, longint c2y, longint p3x, longint p3y,
                                       int seg);
      longint t, u, uu, tt, w0, w1, w2, w3;
      for (int j = 0; j <= seg; j++) begin
         t = (longint'(j) << 16) / seg;
         u = 65536 - t;
         uu = (u * u) >> 16;
         tt = (t * t) >> 16;
         w0 = (uu * u) >> 16;
         w1 = 3 * ((uu * t) >> 16);
         w2 = 3 * ((u * tt) >> 16);
         w3 = (tt * t) >> 16;
         push_sample(floor_div(p0x * w0 + c1x * w1 + c2x * w2 + p3x * w3, 16),
                     floor_div(p0y * w0 + c1y * w1 + c2y * w2 + p3y * w3, 16));
      end
   endfunction

   // Work out the samples that one accepted point causes.
   function automatic void predict_point(logic signed [CW-1:0] px, logic signed [CW-1:0] py,
                                         logic last);
      longint cx, cy, c1x, c1y, c2x, c2y;
      int seg;
      int prior_size;
      seg = (seg_reg < 1) ? 1 : seg_reg;
      cx = px;
      cy = py;
      prior_size = pending_samples.size();
      if (pts_in_curve == 0) begin
         if (last) push_sample(cx, cy);
      end else if (pts_in_curve == 1) begin
         if (last) sample_line(win_x[2], win_y[2], cx, cy, seg);
      end else begin
         if (pts_in_curve == 2) begin
            c1x = win_x[1] + floor_div(win_x[2] - win_x[1], 2);
            c1y = win_y[1] + floor_div(win_y[2] - win_y[1], 2);
         end else begin
            c1x = win_x[1] + floor_div(win_x[1] - win_x[0], 2);
            c1y = win_y[1] + floor_div(win_y[1] - win_y[0], 2);
         end
         c2x = win_x[2] - floor_div(cx - win_x[2], 2);
         c2y = win_y[2] - floor_div(cy - win_y[2], 2);
         sample_span(win_x[1], win_y[1], c1x, c1y, c2x, c2y, win_x[2], win_y[2], seg);
         if (last) begin
            c1x = win_x[2] + floor_div(win_x[2] - win_x[1], 2);
            c1y = win_y[2] + floor_div(win_y[2] - win_y[1], 2);
            c2x = cx - floor_div(cx - win_x[2], 2);
            c2y = cy - floor_div(cy - win_y[2], 2);
            sample_span(win_x[2], win_y[2], c1x, c1y, c2x, c2y, cx, cy, seg);
         end
      end
      if (pending_samples.size() > prior_size) begin
         pending_samples[pending_samples.size() - 1].run_last = 1'b1;
         pending_samples[pending_samples.size() - 1].curve_end = last;
      end
      if (last) begin
         pts_in_curve = 0;
      end else begin
         win_x[0] = win_x[1]; win_y[0] = win_y[1];
         win_x[1] = win_x[2]; win_y[1] = win_y[2];
         win_x[2] = cx;       win_y[2] = cy;
         if (pts_in_curve < 3) pts_in_curve++;
      end
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("Mismatch on %s at sample %0d: got %0d, expected %0d",
               what, sample_count, got, want);
      error_count++;
   endtask

   // Cycle counter and timeout.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Some tests failed");
         $finish;
      end
   end

   // Compare each result transfer with the oldest expected sample.
   always @(posedge clock) begin
      sample_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_samples.size() == 0) begin
            report_mismatch("unexpected sample x", rsp_curve_x, 0);
         end else begin
            want = pending_samples.pop_front();
            if (rsp_curve_x !== want.x) report_mismatch("curve_x", rsp_curve_x, want.x);
            if (rsp_curve_y !== want.y) report_mismatch("curve_y", rsp_curve_y, want.y);
            if (rsp_run_last !== want.run_last)
               report_mismatch("run_last", rsp_run_last, want.run_last);
            if (rsp_curve_end !== want.curve_end)
               report_mismatch("curve_end", rsp_curve_end, want.curve_end);
         end
         sample_count++;
      end
   end

   // The receiver stalls in random bursts while idling is enabled.
   initial begin
      int n;
      forever begin
         @(negedge clock);
         if (idle_enable && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 11);
            rsp_stall <= 1'b1;
            repeat (n) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Send one point and predict its samples when the transfer happens.
   // Valid stays high after a transfer so that points can follow back to back.
   task automatic send_point(logic signed [CW-1:0] px, logic signed [CW-1:0] py,
                             logic last);
      int n;
      if (idle_enable && $urandom_range(0, 4) == 0) begin
         n = $urandom_range(1, 11);
         req_valid <= 1'b0;
         repeat (n) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_point_x <= px;
      req_point_y <= py;
      req_last_point <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_point(px, py, last);
      point_count++;
      @(negedge clock);
   endtask

   task automatic drain_samples();
      req_valid <= 1'b0;
      while (pending_samples.size() != 0) @(negedge clock);
      repeat (12) @(negedge clock);
   endtask

   task automatic write_segments(int value);
      drain_samples();
      csr_wr_en <= 1'b1;
      csr_wr_data <= value[cbs_pkg::SEG_WIDTH-1:0];
      @(negedge clock);
      csr_wr_en <= 1'b0;
      seg_reg = value;
   endtask

   function automatic logic signed [CW-1:0] rand_coord(int mode);
      case (mode)
         0: return $urandom_range(0, 1) ? 24'sh7fffff : 24'sh800000;
         1: return $signed(24'($urandom_range(0, 2048))) - 24'sd1024;
         default: return 24'($urandom);
      endcase
   endfunction

   // Extremes, the short curves and the special cases.
   task automatic test_directed();
      send_point(24'sh000100, 24'shffff00, 1'b1);
      send_point(24'sh7fffff, 24'sh800000, 1'b1);
      send_point(24'sh000000, 24'sh000000, 1'b0);
      send_point(24'sh7fffff, 24'sh7fffff, 1'b1);
      send_point(24'sh800000, 24'sh7fffff, 1'b0);
      send_point(24'sh7fffff, 24'sh800000, 1'b0);
      send_point(24'sh800000, 24'sh7fffff, 1'b1);
      send_point(24'sh001000, 24'sh002000, 1'b0);
      send_point(24'sh003000, 24'shffe000, 1'b0);
      send_point(24'sh005000, 24'sh001000, 1'b0);
      send_point(24'sh7fff00, 24'sh800100, 1'b0);
      send_point(24'sh800000, 24'sh000000, 1'b1);
      send_point(24'sh555555, 24'shaaaaaa, 1'b0);
      send_point(24'shaaaaaa, 24'sh555555, 1'b0);
      send_point(24'sh555555, 24'shaaaaaa, 1'b0);
      send_point(24'shffffff, 24'sh000001, 1'b1);
   endtask

   // Sweep the segment count, including both ends and the zero setting.
   task automatic test_segment_counts();
      int counts [5] = '{1, 31, 0, 2, 7};
      foreach (counts[i]) begin
         write_segments(counts[i]);
         send_point(24'sh010000, 24'sh000000, 1'b0);
         send_point(24'sh020000, 24'sh010000, 1'b0);
         send_point(24'shfe0000, 24'sh7fffff, 1'b1);
         send_point(24'sh000400, 24'sh800000, 1'b0);
         send_point(24'sh7ff000, 24'sh000000, 1'b1);
      end
   endtask

   // Random polylines of random length under random settings.
   task automatic test_random_curves(int points, bit with_idle);
      int len, mode;
      idle_enable = with_idle;
      while (points > 0) begin
         if ($urandom_range(0, 5) == 0) write_segments($urandom_range(0, 31) % 12);
         len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 8);
         mode = $urandom_range(0, 9) == 0 ? 0 : ($urandom_range(0, 2) == 0 ? 1 : 2);
         for (int k = 0; k < len; k++)
            send_point(rand_coord(mode), rand_coord(mode), k == len - 1);
         points -= len;
         if ($urandom_range(0, 15) == 0) drain_samples();
      end
   endtask

   initial begin
      error_count = 0;
      sample_count = 0;
      point_count = 0;
      cycle_count = 0;
      idle_enable = 1'b1;
      pts_in_curve = 0;
      seg_reg = cbs_pkg::SEG_RESET;
      foreach (win_x[i]) begin
         win_x[i] = 0;
         win_y[i] = 0;
      end
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_segment_counts();
      test_random_curves(340, 1'b1);
      test_random_curves(80, 1'b0);

      drain_samples();
      $display("Sent %0d points and checked %0d curve samples", point_count, sample_count);
      $display("Segment counts 0 to 31 region, short and long curves, saturating extremes");
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end
endmodule
